/* hw/rtl/wtseq_pkg.sv */
// Shared types and constants for the welder torch sequencer.
package wtseq_pkg;

	typedef struct packed {
		logic        trigger_raw;
		logic [11:0] arc_current;
		logic [31:0] now_ms;
	} in_word_t;

	typedef struct packed {
		logic       trigger_effective;
		logic       gas_on;
		logic       current_en;
		logic       wire_on;
		logic [2:0] phase_out;
	} out_word_t;

	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 16;

	localparam logic [CfgIdxW-1:0] REG_WELD_MODE = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_PRE_FLOW = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_ON_DELAY = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_OFF_DELAY = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_BURN_BACK = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_POST_FLOW = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_ACTIVE = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_PAUSE = 3'd7;

	localparam logic [1:0] MODE_NORMAL = 2'd0;
	localparam logic [1:0] MODE_SPOT = 2'd1;
	localparam logic [1:0] MODE_PULSE = 2'd2;

	localparam logic [15:0] PRE_FLOW_RST = 16'd300;
	localparam logic [15:0] ON_DELAY_RST = 16'd100;
	localparam logic [15:0] OFF_DELAY_RST = 16'd100;
	localparam logic [15:0] BURN_BACK_RST = 16'd50;
	localparam logic [15:0] POST_FLOW_RST = 16'd1000;
	localparam logic [15:0] ACTIVE_RST = 16'd500;
	localparam logic [15:0] PAUSE_RST = 16'd500;

endpackage

/* hw/rtl/welder_torch_sequencer.sv */
// Welder torch sequencer: trigger mode filter and eight-phase torch sequence.
//
// Input channel (in_valid/in_stall/in_word): one word per update, carrying the
// raw trigger, arc current and millisecond time. Output channel
// (out_valid/out_stall/out_word): exactly one word per input word, in order.
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle; write
// only while no update is in flight.
//
// An accepted word lands in the input register; the mode filter and phase
// logic then run on it against the held phase, deadline and window, and the
// result is loaded into the output register, with out_valid, as the state
// updates. Throughput is one word per cycle while the receiver does not
// stall: the state is a single register set updated by one pass.
//
// Reset clears both registers to empty, the phase to off, the deadline and the
// window to zero, and the configuration to its defaults. When the receiver
// stalls, the output word holds; the input register still drains into the
// output register whenever that one empties, and in_stall rises only when
// both are full.
module welder_torch_sequencer #(
	parameter int ARC_THRESHOLD_DA = 10
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [wtseq_pkg::CfgIdxW-1:0]         cfg_index,
	input  logic [wtseq_pkg::CfgDataW-1:0]        cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  wtseq_pkg::in_word_t                   in_word,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output wtseq_pkg::out_word_t                  out_word
);
	import wtseq_pkg::*;

	localparam logic [11:0] ARC_THR = 12'(ARC_THRESHOLD_DA);

	typedef enum logic [2:0] {
		PH_OFF      = 3'd0,
		PH_PREFLOW  = 3'd1,
		PH_ONDELAY  = 3'd2,
		PH_RUNIN    = 3'd3,
		PH_ON       = 3'd4,
		PH_OFFDELAY = 3'd5,
		PH_BURNBACK = 3'd6,
		PH_POSTFLOW = 3'd7
	} phase_t;

	logic [1:0]  weld_mode_q;
	logic [15:0] pre_flow_q, on_delay_q, off_delay_q, burn_back_q;
	logic [15:0] post_flow_q, active_q, pause_q;

	phase_t      phase_q, phase_d;
	logic [31:0] deadline_q, deadline_d;
	logic [31:0] window_q, window_d;

	in_word_t    word_s1;
	logic        valid_s1;
	out_word_t   out_q;
	logic        out_valid_q;

	logic        advance;
	logic        take_in;

	logic        trig_raw;
	logic [11:0] amps;
	logic [31:0] now;
	logic        idle;
	logic        trig;
	logic [31:0] win_a;
	logic [31:0] win_b;
	logic [15:0] pre_diff;
	logic [15:0] post_diff;

	assign advance = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign take_in = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_word = out_q;

	assign trig_raw = word_s1.trigger_raw;
	assign amps = word_s1.arc_current;
	assign now = word_s1.now_ms;
	assign idle = (phase_q == PH_OFF) || (phase_q == PH_POSTFLOW);
	assign pre_diff = (pre_flow_q > on_delay_q) ? (pre_flow_q - on_delay_q) : 16'd0;
	assign post_diff = (post_flow_q > burn_back_q) ? (post_flow_q - burn_back_q) : 16'd0;

	// mode filter
	always_comb begin
		win_a = window_q;
		win_b = window_q;
		window_d = window_q;
		trig = trig_raw;
		if (weld_mode_q == MODE_SPOT || weld_mode_q == MODE_PULSE) begin
			if (!trig_raw) begin
				trig = 1'b0;
				if (idle) begin
					window_d = '0;
				end
			end else begin
				if (phase_q == PH_ON && window_q == '0) begin
					win_a = now + {16'd0, active_q};
				end
				win_b = win_a;
				if (weld_mode_q == MODE_PULSE && idle && ((window_q + {16'd0, pause_q}) < now)) begin
					win_b = '0;
				end
				window_d = win_b;
				trig = !(win_b != '0 && win_b < now);
			end
		end
	end

	// phase sequence
	always_comb begin
		phase_d = phase_q;
		deadline_d = deadline_q;
		unique case (phase_q)
			PH_OFF: begin
				if (trig) begin
					phase_d = PH_PREFLOW;
					deadline_d = now + {16'd0, pre_diff};
				end else begin
					deadline_d = '0;
				end
			end
			PH_PREFLOW, PH_ONDELAY: begin
				if (trig && now >= deadline_q) begin
					if (phase_q == PH_PREFLOW) begin
						phase_d = PH_ONDELAY;
						deadline_d = now + {16'd0, on_delay_q};
					end else begin
						phase_d = PH_RUNIN;
						deadline_d = now;
					end
				end else if (!trig) begin
					phase_d = PH_OFF;
					deadline_d = now;
				end
			end
			PH_RUNIN: begin
				if (trig && amps > ARC_THR) begin
					phase_d = PH_ON;
				end else if (!trig) begin
					phase_d = PH_OFFDELAY;
					deadline_d = now + {16'd0, off_delay_q};
				end
			end
			PH_ON: begin
				if (!trig) begin
					phase_d = PH_OFFDELAY;
					deadline_d = now + {16'd0, off_delay_q};
				end
			end
			PH_OFFDELAY: begin
				if (now > deadline_q) begin
					phase_d = PH_BURNBACK;
					deadline_d = now + {16'd0, burn_back_q};
				end else if (trig) begin
					phase_d = PH_ON;
				end
			end
			PH_BURNBACK: begin
				if (now >= deadline_q) begin
					phase_d = PH_POSTFLOW;
					deadline_d = now + {16'd0, post_diff};
				end
			end
			PH_POSTFLOW: begin
				if (!trig && now >= deadline_q) begin
					phase_d = PH_OFF;
					deadline_d = '0;
				end else if (trig) begin
					phase_d = PH_ONDELAY;
					deadline_d = now + {16'd0, on_delay_q};
				end
			end
			default: begin
				phase_d = PH_OFF;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weld_mode_q <= MODE_NORMAL;
			pre_flow_q <= PRE_FLOW_RST;
			on_delay_q <= ON_DELAY_RST;
			off_delay_q <= OFF_DELAY_RST;
			burn_back_q <= BURN_BACK_RST;
			post_flow_q <= POST_FLOW_RST;
			active_q <= ACTIVE_RST;
			pause_q <= PAUSE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WELD_MODE: weld_mode_q <= cfg_data[1:0];
				REG_PRE_FLOW: pre_flow_q <= cfg_data;
				REG_ON_DELAY: on_delay_q <= cfg_data;
				REG_OFF_DELAY: off_delay_q <= cfg_data;
				REG_BURN_BACK: burn_back_q <= cfg_data;
				REG_POST_FLOW: post_flow_q <= cfg_data;
				REG_ACTIVE: active_q <= cfg_data;
				REG_PAUSE: pause_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q <= PH_OFF;
			deadline_q <= '0;
			window_q <= '0;
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				phase_q <= phase_d;
				deadline_q <= deadline_d;
				window_q <= window_d;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			word_s1 <= in_word;
		end
		if (advance) begin
			out_q.trigger_effective <= trig;
			out_q.gas_on <= (phase_q != PH_OFF);
			out_q.current_en <= (phase_q >= PH_ONDELAY) && (phase_q <= PH_BURNBACK);
			out_q.wire_on <= (phase_q >= PH_RUNIN) && (phase_q <= PH_OFFDELAY);
			out_q.phase_out <= phase_d;
		end
	end

endmodule
